// ===== src/sall_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted linked list package
// Shared constants, operation codes and control structs for the sorted
// linked list block.
// ----------------------------------------------------------------------------
package sall_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 4;
  localparam int COUNT_W   = 5;

  localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Result of the shared key comparator: stored key against search key.
  typedef struct packed {
    logic lt;
    logic eq;
  } key_cmp_t;

  // Control of the link store.
  typedef struct packed {
    logic wr_en;
    logic clr;
  } link_ctl_t;

endpackage

// ===== src/sall_key_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key store and comparator
// Holds the key of each slot and compares the word read back against the
// key of the current operation with one signed comparator.
// ----------------------------------------------------------------------------
module sall_key_unit import sall_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic                    clk,
  input  logic [IDX_W-1:0]        rd_addr,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic signed [KEY_W-1:0] wr_data,
  input  logic signed [KEY_W-1:0] key,
  output key_cmp_t                cmp
);

  logic signed [KEY_W-1:0] key_mem [SLOTS];
  logic signed [KEY_W-1:0] key_q_r;

  always_ff @(posedge clk) begin
    key_q_r <= key_mem[rd_addr];
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
  end

  assign cmp.lt = key_q_r < key;
  assign cmp.eq = key_q_r == key;

endmodule

// ===== src/sall_link_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link store
// Next-slot links of all slots, with a fill mark that stands in for the
// reset contents of the links that were never written.
// ----------------------------------------------------------------------------
module sall_link_store import sall_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IDX_W = $clog2(SLOTS),
  localparam int LINK_W = $clog2(SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  link_ctl_t         ctl,
  input  logic [IDX_W-1:0]  rd_addr,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [LINK_W-1:0] wr_data,
  output logic [LINK_W-1:0] link
);

  logic [LINK_W-1:0] link_mem [SLOTS];
  logic [LINK_W-1:0] link_q_r;
  logic [IDX_W-1:0]  rd_addr_r;
  logic [LINK_W-1:0] fill_r;
  logic [LINK_W-1:0] fill_nxt;

  always_ff @(posedge clk) begin
    link_q_r  <= link_mem[rd_addr];
    rd_addr_r <= rd_addr;
    if (ctl.wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
  end

  // Slots at or above the fill mark still hold their reset link, i + 1.
  // Slots are handed out in ascending order from the fill mark, so every
  // write lands below it or exactly on it.
  always_comb begin
    fill_nxt = fill_r;
    if (ctl.clr) begin
      fill_nxt = '0;
    end else if (ctl.wr_en && (LINK_W'(wr_addr) == fill_r)) begin
      fill_nxt = fill_r + LINK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign link = (LINK_W'(rd_addr_r) >= fill_r) ? LINK_W'(rd_addr_r) + LINK_W'(1)
                                               : link_q_r;

endmodule

// ===== src/sall_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequencer
// Walks the list one slot per cycle through the key comparator, then
// relinks the slots for insert and delete and registers the result word.
// ----------------------------------------------------------------------------
module sall_ctrl import sall_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int IDX_W = $clog2(SLOTS),
  localparam int LINK_W = $clog2(SLOTS + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_op,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_ok,
  output logic [SLOT_W-1:0]       out_slot,
  output logic [COUNT_W-1:0]      out_entry_count,
  output logic [IDX_W-1:0]        rd_addr,
  output logic                    key_we,
  output logic [IDX_W-1:0]        key_wr_addr,
  output logic signed [KEY_W-1:0] key_op,
  input  key_cmp_t                key_cmp,
  output link_ctl_t               link_ctl,
  output logic [IDX_W-1:0]        link_wr_addr,
  output logic [LINK_W-1:0]       link_wr_data,
  input  logic [LINK_W-1:0]       link_rd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_INS    = 3'd2;
  localparam logic [2:0] S_LINKIN = 3'd3;
  localparam logic [2:0] S_UNLINK = 3'd4;
  localparam logic [2:0] S_FREE   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

  logic [2:0]              state_r, state_nxt;
  logic [OP_W-1:0]         op_r, op_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [LINK_W-1:0]       cur_r, cur_nxt;
  logic [LINK_W-1:0]       prev_r, prev_nxt;
  logic [LINK_W-1:0]       steps_r, steps_nxt;
  logic [LINK_W-1:0]       after_r, after_nxt;
  logic [LINK_W-1:0]       list_head_r, list_head_nxt;
  logic [LINK_W-1:0]       free_head_r, free_head_nxt;
  logic [LINK_W-1:0]       count_r, count_nxt;
  logic                    res_ok_r, res_ok_nxt;
  logic [IDX_W-1:0]        res_slot_r, res_slot_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_ok_r, out_ok_nxt;
  logic [SLOT_W-1:0]       out_slot_r, out_slot_nxt;
  logic [COUNT_W-1:0]      out_cnt_r, out_cnt_nxt;

  logic cur_live;
  logic walk_go;
  logic hit;

  assign cur_live = cur_r < NIL;
  assign walk_go  = cur_live && (steps_r < NIL) && key_cmp.lt;
  assign hit      = cur_live && key_cmp.eq;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    after_nxt     = after_r;
    list_head_nxt = list_head_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    res_ok_nxt    = res_ok_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_slot_nxt  = out_slot_r;
    out_cnt_nxt   = out_cnt_r;
    rd_addr       = cur_r[IDX_W-1:0];
    key_we        = 1'b0;
    link_ctl      = '0;
    link_wr_addr  = prev_r[IDX_W-1:0];
    link_wr_data  = cur_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_op;
          key_nxt = in_key;
          if (in_op == OP_CLEAR) begin
            list_head_nxt = NIL;
            free_head_nxt = '0;
            count_nxt     = '0;
            link_ctl.clr  = 1'b1;
            res_ok_nxt    = 1'b1;
            res_slot_nxt  = '0;
            state_nxt     = S_EMIT;
          end else begin
            cur_nxt   = list_head_r;
            prev_nxt  = NIL;
            steps_nxt = '0;
            rd_addr   = list_head_r[IDX_W-1:0];
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        // The key and link of the current slot arrive from the stores here.
        if (walk_go) begin
          prev_nxt  = cur_r;
          cur_nxt   = link_rd;
          steps_nxt = steps_r + LINK_W'(1);
          rd_addr   = link_rd[IDX_W-1:0];
        end else begin
          after_nxt    = link_rd;
          res_ok_nxt   = 1'b0;
          res_slot_nxt = '0;
          state_nxt    = S_EMIT;
          case (op_r)
            OP_SEARCH: begin
              if (hit) begin
                res_ok_nxt   = 1'b1;
                res_slot_nxt = cur_r[IDX_W-1:0];
              end
            end
            OP_INSERT: begin
              if ((free_head_r < NIL) && !hit) begin
                res_slot_nxt = free_head_r[IDX_W-1:0];
                rd_addr      = free_head_r[IDX_W-1:0];
                state_nxt    = S_INS;
              end
            end
            OP_DELETE: begin
              if (hit) begin
                res_slot_nxt = cur_r[IDX_W-1:0];
                state_nxt    = S_UNLINK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        // The new slot points at the slot where the walk stopped.
        link_ctl.wr_en = 1'b1;
        link_wr_addr   = res_slot_r;
        link_wr_data   = cur_r;
        key_we         = 1'b1;
        free_head_nxt  = link_rd;
        state_nxt      = S_LINKIN;
      end
      S_LINKIN: begin
        if (prev_r < NIL) begin
          link_ctl.wr_en = 1'b1;
          link_wr_addr   = prev_r[IDX_W-1:0];
          link_wr_data   = LINK_W'(res_slot_r);
        end else begin
          list_head_nxt = LINK_W'(res_slot_r);
        end
        count_nxt  = count_r + LINK_W'(1);
        res_ok_nxt = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_UNLINK: begin
        if (prev_r < NIL) begin
          link_ctl.wr_en = 1'b1;
          link_wr_addr   = prev_r[IDX_W-1:0];
          link_wr_data   = after_r;
        end else begin
          list_head_nxt = after_r;
        end
        state_nxt = S_FREE;
      end
      S_FREE: begin
        link_ctl.wr_en = 1'b1;
        link_wr_addr   = res_slot_r;
        link_wr_data   = free_head_r;
        free_head_nxt  = LINK_W'(res_slot_r);
        if (count_r != '0) begin
          count_nxt = count_r - LINK_W'(1);
        end
        res_ok_nxt = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_slot_nxt  = SLOT_W'(res_slot_r);
          out_cnt_nxt   = COUNT_W'(count_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      list_head_r <= NIL;
      free_head_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    steps_r    <= steps_nxt;
    after_r    <= after_nxt;
    res_ok_r   <= res_ok_nxt;
    res_slot_r <= res_slot_nxt;
    out_ok_r   <= out_ok_nxt;
    out_slot_r <= out_slot_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign in_stall        = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_slot        = out_slot_r;
  assign out_entry_count = out_cnt_r;
  assign key_wr_addr     = res_slot_r;
  assign key_op          = key_r;

endmodule

// ===== src/sorted_array_linked_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array linked list
// Keeps distinct signed keys in ascending order in a fixed set of slots,
// with a free chain, and answers search, insert, delete and clear.
// ----------------------------------------------------------------------------
// One word is taken at a time. Search, insert and delete walk the list from
// its head at one slot per cycle through a single key store read port and one
// signed comparator, and the input stays stalled while the walk runs and, for
// insert and delete, while the slots are relinked. A successful insert or
// delete passes at most SLOTS - 1 slots. The result word waits in an output
// register, and a new input word is taken while it waits. No clearing pass
// follows reset.
module sorted_array_linked_list import sall_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_op,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_ok,
  output logic [SLOT_W-1:0]       out_slot,
  output logic [COUNT_W-1:0]      out_entry_count
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LINK_W = $clog2(SLOTS + 1);

  logic [IDX_W-1:0]        rd_addr;
  logic                    key_we;
  logic [IDX_W-1:0]        key_wr_addr;
  logic signed [KEY_W-1:0] key_op;
  key_cmp_t                key_cmp;
  link_ctl_t               link_ctl;
  logic [IDX_W-1:0]        link_wr_addr;
  logic [LINK_W-1:0]       link_wr_data;
  logic [LINK_W-1:0]       link_rd;

  sall_key_unit #(.SLOTS(SLOTS)) u_key (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr_en   (key_we),
    .wr_addr (key_wr_addr),
    .wr_data (key_op),
    .key     (key_op),
    .cmp     (key_cmp)
  );

  sall_link_store #(.SLOTS(SLOTS)) u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (link_ctl),
    .rd_addr (rd_addr),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .link    (link_rd)
  );

  sall_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_slot        (out_slot),
    .out_entry_count (out_entry_count),
    .rd_addr         (rd_addr),
    .key_we          (key_we),
    .key_wr_addr     (key_wr_addr),
    .key_op          (key_op),
    .key_cmp         (key_cmp),
    .link_ctl        (link_ctl),
    .link_wr_addr    (link_wr_addr),
    .link_wr_data    (link_wr_data),
    .link_rd         (link_rd)
  );

endmodule

// ===== tb/sv/sall_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted linked list checker package
// Tracks the slot chains of the sorted linked list, predicts the reply to
// every accepted word and compares each returned reply with the oldest one.
// ----------------------------------------------------------------------------
package sall_tb_pkg;
  import sall_pkg::*;

  typedef struct {
    bit                 ok;
    bit [SLOT_W-1:0]    slot;
    bit [COUNT_W-1:0]   entry_count;
  } list_reply_t;

  class sorted_list_tracker;
    // A link value of SLOTS_DEF marks the end of a chain.
    logic signed [KEY_W-1:0] key_store [SLOTS_DEF];
    int                      next_link [SLOTS_DEF];
    int                      list_head;
    int                      free_head;
    int                      count;
    list_reply_t             pending_replies [$];
    int                      errors;

    function new();
      errors = 0;
      foreach (key_store[i]) key_store[i] = '0;
      restore_chains();
    endfunction

    function void restore_chains();
      for (int i = 0; i < SLOTS_DEF; i++) next_link[i] = i + 1;
      list_head = SLOTS_DEF;
      free_head = 0;
      count     = 0;
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    // Called for each word taken by the block.
    function void apply_op(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] k);
      list_reply_t r;
      int          cur;
      int          prev;
      int          steps;
      int          fresh;
      bit          hit;
      r.ok   = 0;
      r.slot = '0;
      if (op == OP_CLEAR) begin
        restore_chains();
        r.ok = 1;
      end else begin
        // Find the first slot whose key is not below k.
        cur   = list_head;
        prev  = SLOTS_DEF;
        steps = 0;
        while (cur < SLOTS_DEF && steps < SLOTS_DEF && key_store[cur] < k) begin
          prev = cur;
          cur  = next_link[cur];
          steps++;
        end
        if (cur >= SLOTS_DEF || key_store[cur] < k) cur = SLOTS_DEF;
        hit = (cur < SLOTS_DEF) && (key_store[cur] == k);
        case (op)
          OP_SEARCH: begin
            if (hit) begin
              r.ok   = 1;
              r.slot = cur[SLOT_W-1:0];
            end
          end
          OP_INSERT: begin
            if (free_head < SLOTS_DEF && !hit) begin
              fresh            = free_head;
              free_head        = next_link[fresh];
              key_store[fresh] = k;
              if (prev >= SLOTS_DEF) begin
                next_link[fresh] = list_head;
                list_head        = fresh;
              end else begin
                next_link[fresh] = next_link[prev];
                next_link[prev]  = fresh;
              end
              count++;
              r.ok   = 1;
              r.slot = fresh[SLOT_W-1:0];
            end
          end
          default: begin
            if (hit) begin
              if (prev >= SLOTS_DEF) list_head = next_link[cur];
              else next_link[prev] = next_link[cur];
              next_link[cur] = free_head;
              free_head      = cur;
              if (count > 0) count--;
              r.ok   = 1;
              r.slot = cur[SLOT_W-1:0];
            end
          end
        endcase
      end
      r.entry_count = count[COUNT_W-1:0];
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic ok, logic [SLOT_W-1:0] slot,
                              logic [COUNT_W-1:0] entry_count);
      list_reply_t r;
      if (pending_replies.size() == 0) begin
        $error("reply word with none expected: ok %0b slot %0d entry_count %0d",
               ok, slot, entry_count);
        errors++;
        return;
      end
      r = pending_replies.pop_front();
      if (ok !== r.ok) begin
        $error("ok: expected %0b, actual %0b", r.ok, ok);
        errors++;
      end
      if (slot !== r.slot) begin
        $error("slot: expected %0d, actual %0d", r.slot, slot);
        errors++;
      end
      if (entry_count !== r.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", r.entry_count, entry_count);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_sorted_array_linked_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array linked list testbench
// Drives search, insert, delete and clear words with random gaps and output
// stalls, and checks every reply against a tracked copy of the slot chains.
// ----------------------------------------------------------------------------
module tb_sorted_array_linked_list;
  import sall_pkg::*;
  import sall_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 24;
  localparam int PHASES      = 5;
  localparam int PHASE_WORDS = 80;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         in_op;
  logic signed [KEY_W-1:0] in_key;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_ok;
  logic [SLOT_W-1:0]       out_slot;
  logic [COUNT_W-1:0]      out_entry_count;

  sorted_list_tracker      tracker = new();
  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
  bit                      calm;
  int                      cycles;
  int                      stall_left;

  sorted_array_linked_list u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_slot        (out_slot),
    .out_entry_count (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none while calm is set.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 80) return $signed($urandom_range(0, 40)) - 20;
    return $urandom;
  endfunction

  task automatic send_word(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] k);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_op    = op;
    in_key   = k;
    do @(posedge clk); while (in_stall);
    tracker.apply_op(op, k);
  endtask

  task automatic drain_replies();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, lowered at the falling edge.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall  = 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_reply(out_ok, out_slot, out_entry_count);
  end

  initial begin
    int               ins_pct [PHASES];
    int               del_pct [PHASES];
    int               r;
    logic [OP_W-1:0]  op;
    ins_pct = '{45, 75, 20, 45, 50};
    del_pct = '{27, 8, 53, 27, 25};
    cycles   = 0;
    calm     = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_op    = OP_SEARCH;
    in_key   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty list, key extremes, duplicate, full list, misses, clear.
    send_word(OP_SEARCH, 32'sd0);
    send_word(OP_DELETE, 32'sd0);
    send_word(OP_INSERT, 32'sh8000_0000);
    send_word(OP_INSERT, 32'sh7fff_ffff);
    send_word(OP_INSERT, 32'sd0);
    send_word(OP_INSERT, -32'sd1);
    send_word(OP_INSERT, 32'sd0);
    send_word(OP_SEARCH, 32'sh8000_0000);
    send_word(OP_SEARCH, 32'sh7fff_ffff);
    send_word(OP_SEARCH, 32'sd5);
    for (int i = 0; i < SLOTS_DEF - 4; i++) send_word(OP_INSERT, 1000 + 37 * i);
    send_word(OP_INSERT, 32'sd7);
    send_word(OP_DELETE, 32'sd0);
    send_word(OP_DELETE, 32'sh8000_0000);
    send_word(OP_DELETE, 32'sd5);
    send_word(OP_DELETE, 32'sh7fff_ffff);
    send_word(OP_CLEAR, 32'shffff_ffff);
    send_word(OP_SEARCH, -32'sd1);
    drain_replies();

    for (int p = 0; p < PHASES; p++) begin
      // A fresh pool per phase; more keys than slots so the list can fill.
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7fff_ffff;
      key_pool[2] = 32'sd0;
      key_pool[3] = -32'sd1;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      calm = (p == 3);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct[p]) op = OP_INSERT;
        else if (r < ins_pct[p] + del_pct[p]) op = OP_DELETE;
        else if (r < 97) op = OP_SEARCH;
        else op = OP_CLEAR;
        send_word(op, pick_key());
      end
      // The sender holds off until every reply of the phase is back.
      drain_replies();
    end

    calm = 1'b0;
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
